// File: hw/rtl/thermal_dvfs_bisect_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// thermal dvfs controller assertion macros
// concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef THERMAL_DVFS_BISECT_CONTROLLER_UNIT_ASSERT_SVH
`define THERMAL_DVFS_BISECT_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TDVFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tdvfs assertion failed");
`define TDVFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdvfs assertion failed");
`else
`define TDVFS_ASSERT(lbl, clk, rst_n, prop)
`define TDVFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/tdvfs_pkg.sv
// ----------------------------------------------------------------------------
// tdvfs_pkg
// shared types, widths and reset values of the thermal dvfs controller
// ----------------------------------------------------------------------------
`default_nettype none

package tdvfs_pkg;

  localparam int unsigned NUM_CORES_DEF = 64;

  localparam int unsigned FREQ_W      = 14;
  localparam int unsigned TEMP_W      = 13;
  localparam int unsigned STEP_W      = 12;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned CORE_CNT_W  = 11;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned FIFO_DEPTH  = 2;

  localparam logic [FREQ_W-1:0] MIN_FREQ_RST   = 14'd1000;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST   = 14'd4000;
  localparam logic [TEMP_W-1:0] TEMP_LOW_RST   = 13'd960;
  localparam logic [TEMP_W-1:0] TEMP_GOAL_RST  = 13'd1120;
  localparam logic [TEMP_W-1:0] TEMP_HIGH_RST  = 13'd1280;
  localparam logic [TEMP_W-1:0] TEMP_CRIT_RST  = 13'd1440;
  localparam logic [STEP_W-1:0] F_STEP_RST     = 12'd200;
  localparam logic [STEP_W-1:0] FINE_FLOOR_RST = 12'd25;

  typedef enum logic [2:0] {
    ACT_IDLE      = 3'd0,
    ACT_EMERGENCY = 3'd1,
    ACT_DOWN      = 3'd2,
    ACT_UP        = 3'd3,
    ACT_FINE      = 3'd4,
    ACT_HOLD      = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    CL_IDLE   = 3'd0,
    CL_RANGE  = 3'd1,
    CL_EMERG  = 3'd2,
    CL_DOWN   = 3'd3,
    CL_UP     = 3'd4,
    CL_BAND   = 3'd5
  } class_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_FREQ   = 3'd0,
    REG_MAX_FREQ   = 3'd1,
    REG_TEMP_LOW   = 3'd2,
    REG_TEMP_GOAL  = 3'd3,
    REG_TEMP_HIGH  = 3'd4,
    REG_TEMP_CRIT  = 3'd5,
    REG_F_STEP     = 3'd6,
    REG_FINE_FLOOR = 3'd7
  } reg_e;

  typedef struct packed {
    logic [FREQ_W-1:0] min_freq;
    logic [FREQ_W-1:0] max_freq;
    logic [TEMP_W-1:0] temp_low;
    logic [TEMP_W-1:0] temp_goal;
    logic [TEMP_W-1:0] temp_high;
    logic [TEMP_W-1:0] temp_critical;
    logic [STEP_W-1:0] f_step;
    logic [STEP_W-1:0] fine_floor;
  } cfg_t;

  typedef struct packed {
    class_e            cls;
    logic              gt_goal;
    logic              eq_goal;
    logic [IDX_W-1:0]  core_index;
    logic [FREQ_W-1:0] old_freq;
  } item_t;

endpackage

`default_nettype wire

// File: hw/rtl/thermal_dvfs_bisect_controller_unit.sv
// a taken input beat passes the queue, the state read register and the output register
// the back end completes one evaluation before it takes the next, as the per-core
//   state read-modify-write goes through the single port of the state memory
// the two-entry queue keeps the input ready while a result waits on the output
// reset: control and limit registers return to their defaults, per-core state
//   reads as its reset value at once through valid flags, so no clearing pass is needed
// ----------------------------------------------------------------------------
// thermal_dvfs_bisect_controller_unit
// banded thermal frequency controller with per-core fine step bisection
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_dvfs_bisect_controller_unit #(
  parameter int unsigned NUM_CORES = tdvfs_pkg::NUM_CORES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tdvfs_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [tdvfs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // core_index[5:0], temperature[18:6], old_frequency[32:19], zero pad
  input  wire logic [tdvfs_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // core_active[0]
  input  wire logic                                s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // new_frequency[13:0], zero pad
  output logic [tdvfs_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  // action_taken[2:0]
  output logic [2:0]                               m_axis_tuser_o
);

  tdvfs_pkg::cfg_t               cfg_q;
  logic                          q_push, q_full, q_pop, q_empty;
  tdvfs_pkg::item_t              q_in, q_out;
  logic [tdvfs_pkg::FREQ_W-1:0]  res_freq;
  tdvfs_pkg::action_e            res_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_freq      <= tdvfs_pkg::MIN_FREQ_RST;
      cfg_q.max_freq      <= tdvfs_pkg::MAX_FREQ_RST;
      cfg_q.temp_low      <= tdvfs_pkg::TEMP_LOW_RST;
      cfg_q.temp_goal     <= tdvfs_pkg::TEMP_GOAL_RST;
      cfg_q.temp_high     <= tdvfs_pkg::TEMP_HIGH_RST;
      cfg_q.temp_critical <= tdvfs_pkg::TEMP_CRIT_RST;
      cfg_q.f_step        <= tdvfs_pkg::F_STEP_RST;
      cfg_q.fine_floor    <= tdvfs_pkg::FINE_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tdvfs_pkg::REG_MIN_FREQ:   cfg_q.min_freq      <= cfg_wdata_i;
        tdvfs_pkg::REG_MAX_FREQ:   cfg_q.max_freq      <= cfg_wdata_i;
        tdvfs_pkg::REG_TEMP_LOW:   cfg_q.temp_low      <= cfg_wdata_i[12:0];
        tdvfs_pkg::REG_TEMP_GOAL:  cfg_q.temp_goal     <= cfg_wdata_i[12:0];
        tdvfs_pkg::REG_TEMP_HIGH:  cfg_q.temp_high     <= cfg_wdata_i[12:0];
        tdvfs_pkg::REG_TEMP_CRIT:  cfg_q.temp_critical <= cfg_wdata_i[12:0];
        tdvfs_pkg::REG_F_STEP:     cfg_q.f_step        <= cfg_wdata_i[11:0];
        tdvfs_pkg::REG_FINE_FLOOR: cfg_q.fine_floor    <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  tdvfs_front #(
    .NUM_CORES (NUM_CORES)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_i           (cfg_q),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  tdvfs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  tdvfs_back #(
    .NUM_CORES (NUM_CORES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_item_i   (q_out),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .freq_o     (res_freq),
    .action_o   (res_act)
  );

  assign m_axis_tdata_o = {{(tdvfs_pkg::OUT_TDATA_W - tdvfs_pkg::FREQ_W){1'b0}}, res_freq};
  assign m_axis_tuser_o = res_act;

endmodule

`default_nettype wire

// File: hw/rtl/tdvfs_front.sv
// ----------------------------------------------------------------------------
// tdvfs_front
// accepts evaluation beats and sorts them against the temperature thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module tdvfs_front #(
  parameter int unsigned NUM_CORES = tdvfs_pkg::NUM_CORES_DEF
) (
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [tdvfs_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  wire logic                               s_axis_tuser_i,
  input  wire tdvfs_pkg::cfg_t                    cfg_i,
  input  wire logic                               q_full_i,
  output logic                                    q_push_o,
  output tdvfs_pkg::item_t                        q_item_o
);

  localparam logic [tdvfs_pkg::CORE_CNT_W-1:0] NumCoresV = tdvfs_pkg::CORE_CNT_W'(NUM_CORES);

  logic [tdvfs_pkg::IDX_W-1:0]        idx;
  logic signed [tdvfs_pkg::TEMP_W-1:0] temp;
  logic [tdvfs_pkg::CORE_CNT_W-1:0]   idx_ext;
  logic                               in_range;

  assign idx      = s_axis_tdata_i[5:0];
  assign temp     = $signed(s_axis_tdata_i[18:6]);
  assign idx_ext  = {{(tdvfs_pkg::CORE_CNT_W - tdvfs_pkg::IDX_W){1'b0}}, idx};
  assign in_range = idx_ext < NumCoresV;

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_item_o            = '0;
    q_item_o.core_index = idx;
    q_item_o.old_freq   = s_axis_tdata_i[32:19];
    q_item_o.gt_goal    = temp > $signed(cfg_i.temp_goal);
    q_item_o.eq_goal    = temp == $signed(cfg_i.temp_goal);
    // priority order of the rules
    if (!s_axis_tuser_i) begin
      q_item_o.cls = tdvfs_pkg::CL_IDLE;
    end else if (!in_range) begin
      q_item_o.cls = tdvfs_pkg::CL_RANGE;
    end else if (temp > $signed(cfg_i.temp_critical)) begin
      q_item_o.cls = tdvfs_pkg::CL_EMERG;
    end else if (temp > $signed(cfg_i.temp_high)) begin
      q_item_o.cls = tdvfs_pkg::CL_DOWN;
    end else if (temp < $signed(cfg_i.temp_low)) begin
      q_item_o.cls = tdvfs_pkg::CL_UP;
    end else begin
      q_item_o.cls = tdvfs_pkg::CL_BAND;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tdvfs_fifo.sv
// ----------------------------------------------------------------------------
// tdvfs_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module tdvfs_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire tdvfs_pkg::item_t item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output tdvfs_pkg::item_t      item_o,
  output logic                  empty_o
);

  localparam int unsigned Depth = tdvfs_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tdvfs_pkg::item_t entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == FullCnt;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tdvfs_back.sv
// ----------------------------------------------------------------------------
// tdvfs_back
// per-core state read-modify-write and frequency selection
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermal_dvfs_bisect_controller_unit_assert.svh"

module tdvfs_back #(
  parameter int unsigned NUM_CORES = tdvfs_pkg::NUM_CORES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tdvfs_pkg::cfg_t                   cfg_i,
  input  wire logic                              q_empty_i,
  input  wire tdvfs_pkg::item_t                  q_item_i,
  output logic                                   q_pop_o,
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic [tdvfs_pkg::FREQ_W-1:0]           freq_o,
  output tdvfs_pkg::action_e                     action_o
);

  localparam int unsigned AddrW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int unsigned WordW = tdvfs_pkg::STEP_W + 2;
  localparam int unsigned PadW  = tdvfs_pkg::CORE_CNT_W - tdvfs_pkg::IDX_W;
  localparam logic signed [15:0] FreqMax = 16'sd16383;

  typedef enum logic [1:0] {
    ST_RD = 2'b01,
    ST_EX = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  tdvfs_pkg::item_t              item_q;
  logic [WordW-1:0]              st_mem [NUM_CORES];
  logic [WordW-1:0]              word_q;
  logic                          vld_rd_q;
  logic [NUM_CORES-1:0]          vld_q;
  logic                          out_valid_q;
  logic [tdvfs_pkg::FREQ_W-1:0]  freq_q;
  tdvfs_pkg::action_e            action_q;

  logic                          pop, fire, st_we, want_we;
  logic                          fine_fire, freq_in_lim;
  logic [AddrW-1:0]              addr_pop, addr_ex;
  logic [tdvfs_pkg::CORE_CNT_W-1:0] idx_pop_ext, idx_ex_ext;

  logic [tdvfs_pkg::STEP_W-1:0]  step_cur, step_half, step_new;
  logic [1:0]                    dir_cur, dir_new;
  logic signed [15:0]            oldf, lo, hi, sum, bounded, newf;
  tdvfs_pkg::action_e            res_act;
  logic [tdvfs_pkg::FREQ_W-1:0]  res_freq;

  assign idx_pop_ext = {{PadW{1'b0}}, q_item_i.core_index};
  assign idx_ex_ext  = {{PadW{1'b0}}, item_q.core_index};
  assign addr_pop    = idx_pop_ext[AddrW-1:0];
  assign addr_ex     = idx_ex_ext[AddrW-1:0];

  assign pop     = (state_q == ST_RD) && !q_empty_i;
  assign fire    = (state_q == ST_EX) && (!out_valid_q || m_tready_i);
  assign st_we   = fire && want_we;
  assign q_pop_o = pop;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RD:   if (pop) state_d = ST_EX;
      ST_EX:   if (fire) state_d = ST_RD;
      default: state_d = ST_RD;
    endcase
  end

  // state of a core not yet written reads as the reset value
  always_comb begin
    step_cur  = vld_rd_q ? word_q[WordW-1:2] : tdvfs_pkg::F_STEP_RST;
    dir_cur   = vld_rd_q ? word_q[1:0] : tdvfs_pkg::DIR_NONE;
    step_half = step_cur >> 1;
    oldf      = $signed({2'b00, item_q.old_freq});
    lo        = $signed({2'b00, cfg_i.min_freq});
    hi        = $signed({2'b00, cfg_i.max_freq});
    sum       = '0;
    bounded   = '0;
    newf      = oldf;
    res_act   = tdvfs_pkg::ACT_HOLD;
    want_we   = 1'b0;
    step_new  = cfg_i.f_step;
    dir_new   = tdvfs_pkg::DIR_NONE;
    case (item_q.cls)
      tdvfs_pkg::CL_IDLE: begin
        newf    = hi;
        res_act = tdvfs_pkg::ACT_IDLE;
      end
      tdvfs_pkg::CL_EMERG: begin
        newf    = lo;
        res_act = tdvfs_pkg::ACT_EMERGENCY;
        want_we = 1'b1;
      end
      tdvfs_pkg::CL_DOWN: begin
        sum     = oldf - $signed({4'b0000, cfg_i.f_step});
        newf    = (sum < lo) ? lo : sum;
        res_act = tdvfs_pkg::ACT_DOWN;
        want_we = 1'b1;
      end
      tdvfs_pkg::CL_UP: begin
        sum     = oldf + $signed({4'b0000, cfg_i.f_step});
        newf    = (sum > hi) ? hi : sum;
        res_act = tdvfs_pkg::ACT_UP;
        want_we = 1'b1;
      end
      tdvfs_pkg::CL_BAND: begin
        if (step_cur >= cfg_i.fine_floor && !item_q.eq_goal) begin
          dir_new  = item_q.gt_goal ? tdvfs_pkg::DIR_DOWN : tdvfs_pkg::DIR_UP;
          step_new = step_cur;
          // reversal halves the step, floored at the minimum fine step
          if (dir_cur != tdvfs_pkg::DIR_NONE && dir_cur != dir_new) begin
            step_new = (step_half < cfg_i.fine_floor) ? cfg_i.fine_floor : step_half;
          end
          if (dir_new == tdvfs_pkg::DIR_UP) begin
            sum = oldf + $signed({4'b0000, step_new});
          end else begin
            sum = oldf - $signed({4'b0000, step_new});
          end
          bounded = (sum < lo) ? lo : sum;
          newf    = (bounded > hi) ? hi : bounded;
          res_act = tdvfs_pkg::ACT_FINE;
          want_we = 1'b1;
        end
      end
      default: begin
        newf    = oldf;
        res_act = tdvfs_pkg::ACT_HOLD;
      end
    endcase
    if (newf < 16'sd0) begin
      res_freq = '0;
    end else if (newf > FreqMax) begin
      res_freq = FreqMax[tdvfs_pkg::FREQ_W-1:0];
    end else begin
      res_freq = newf[tdvfs_pkg::FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[addr_ex] <= {step_new, dir_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      word_q   <= st_mem[addr_pop];
      vld_rd_q <= vld_q[addr_pop];
      item_q   <= q_item_i;
    end
    if (fire) begin
      freq_q   <= res_freq;
      action_q <= res_act;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RD;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (st_we) begin
        vld_q[addr_ex] <= 1'b1;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign freq_o     = freq_q;
  assign action_o   = action_q;

  // fine move issued with an ordered pair of limits, and the beat it left behind
  assign fine_fire   = fire && (res_act == tdvfs_pkg::ACT_FINE) &&
                       (cfg_i.min_freq <= cfg_i.max_freq);
  assign freq_in_lim = (freq_o >= cfg_i.min_freq) && (freq_o <= cfg_i.max_freq);

  `TDVFS_ASSERT_NEXT(a_pop_leads_to_ex, clk_i, rst_ni, pop, state_q == ST_EX)
  `TDVFS_ASSERT_NEXT(a_fire_shows_beat, clk_i, rst_ni, fire, m_tvalid_o)
  `TDVFS_ASSERT_NEXT(a_no_back_to_back_write, clk_i, rst_ni, st_we, !st_we)
  `TDVFS_ASSERT_NEXT(a_fine_within_limits, clk_i, rst_ni, fine_fire, freq_in_lim)

endmodule

`default_nettype wire

// File: test/tb_thermal_dvfs_bisect_controller_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermal_dvfs_bisect_controller_unit_checker
// watches the register port and both streams, predicts every frequency
// setting from its own copy of the limits and per-core fine step state, and
// compares each result beat with the oldest prediction
// ----------------------------------------------------------------------------

module tb_thermal_dvfs_bisect_controller_unit_checker
  import tdvfs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [2:0]             m_tuser_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    action_e           act;
  } freq_setting_t;

  // limits as last written
  int min_freq_q, max_freq_q, low_q, goal_q, high_q, crit_q, f_step_q, min_fine_q;

  logic [STEP_W-1:0] fine_step_q [NUM_CORES_DEF];
  dir_e              heading_q   [NUM_CORES_DEF];

  freq_setting_t due_settings_q [$];
  freq_setting_t want;

  // works out the new setting of one core and updates its fine step state
  function automatic freq_setting_t next_setting(input int core, input logic active,
                                                 input int temp, input int oldf);
    int            newf;
    int            step;
    dir_e          heading;
    action_e       act;
    freq_setting_t res;
    newf = oldf;
    act  = ACT_HOLD;
    if (!active) begin
      newf = max_freq_q;
      act  = ACT_IDLE;
    end else if (temp > crit_q) begin
      newf = min_freq_q;
      act  = ACT_EMERGENCY;
      fine_step_q[core] = f_step_q[STEP_W-1:0];
      heading_q[core]   = DIR_NONE;
    end else if (temp > high_q) begin
      newf = oldf - f_step_q;
      if (newf < min_freq_q) newf = min_freq_q;
      act = ACT_DOWN;
      fine_step_q[core] = f_step_q[STEP_W-1:0];
      heading_q[core]   = DIR_NONE;
    end else if (temp < low_q) begin
      newf = oldf + f_step_q;
      if (newf > max_freq_q) newf = max_freq_q;
      act = ACT_UP;
      fine_step_q[core] = f_step_q[STEP_W-1:0];
      heading_q[core]   = DIR_NONE;
    end else if (int'(fine_step_q[core]) >= min_fine_q && temp != goal_q) begin
      heading = (temp > goal_q) ? DIR_DOWN : DIR_UP;
      step    = int'(fine_step_q[core]);
      // reversal halves the fine step, floored at the minimum fine step
      if (heading_q[core] != DIR_NONE && heading_q[core] != heading) begin
        step = step >> 1;
        if (step < min_fine_q) step = min_fine_q;
        fine_step_q[core] = step[STEP_W-1:0];
        step = int'(fine_step_q[core]);
      end
      newf = (heading == DIR_UP) ? oldf + step : oldf - step;
      if (newf < min_freq_q) newf = min_freq_q;
      if (newf > max_freq_q) newf = max_freq_q;
      heading_q[core] = heading;
      act = ACT_FINE;
    end
    if (newf < 0) newf = 0;
    if (newf > 16383) newf = 16383;
    res.freq = newf[FREQ_W-1:0];
    res.act  = act;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q = int'(MIN_FREQ_RST);
      max_freq_q = int'(MAX_FREQ_RST);
      low_q      = $signed(TEMP_LOW_RST);
      goal_q     = $signed(TEMP_GOAL_RST);
      high_q     = $signed(TEMP_HIGH_RST);
      crit_q     = $signed(TEMP_CRIT_RST);
      f_step_q   = int'(F_STEP_RST);
      min_fine_q = int'(FINE_FLOOR_RST);
      for (int k = 0; k < NUM_CORES_DEF; k++) begin
        fine_step_q[k] = F_STEP_RST;
        heading_q[k]   = DIR_NONE;
      end
      due_settings_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_addr_i))
          REG_MIN_FREQ:   min_freq_q = int'(cfg_wdata_i[FREQ_W-1:0]);
          REG_MAX_FREQ:   max_freq_q = int'(cfg_wdata_i[FREQ_W-1:0]);
          REG_TEMP_LOW:   low_q      = $signed(cfg_wdata_i[TEMP_W-1:0]);
          REG_TEMP_GOAL:  goal_q     = $signed(cfg_wdata_i[TEMP_W-1:0]);
          REG_TEMP_HIGH:  high_q     = $signed(cfg_wdata_i[TEMP_W-1:0]);
          REG_TEMP_CRIT:  crit_q     = $signed(cfg_wdata_i[TEMP_W-1:0]);
          REG_F_STEP:     f_step_q   = int'(cfg_wdata_i[STEP_W-1:0]);
          REG_FINE_FLOOR: min_fine_q = int'(cfg_wdata_i[STEP_W-1:0]);
          default: ;
        endcase
      end

      if (m_tvalid_i && m_tready_i) begin
        if (due_settings_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result beat with nothing expected, expected none actual %0d/%0d",
                   $time, m_tdata_i, m_tuser_i);
        end else begin
          want = due_settings_q.pop_front();
          if (m_tdata_i !== {{(OUT_TDATA_W-FREQ_W){1'b0}}, want.freq}) begin
            fail_count_o++;
            $display("%0t: new_frequency mismatch, expected %0d actual %0d",
                     $time, want.freq, m_tdata_i);
          end
          if (m_tuser_i !== want.act) begin
            fail_count_o++;
            $display("%0t: action_taken mismatch, expected %0d actual %0d",
                     $time, want.act, m_tuser_i);
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        due_settings_q.push_back(next_setting(int'(s_tdata_i[5:0]), s_tuser_i,
                                              $signed(s_tdata_i[18:6]),
                                              int'(s_tdata_i[32:19])));
      end
      pending_o = due_settings_q.size();
    end
  end

endmodule

// File: test/tb_thermal_dvfs_bisect_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermal_dvfs_bisect_controller_unit
// drives core evaluations through the thermal controller under several limit
// settings and idling patterns; the checker beside the block judges results
// ----------------------------------------------------------------------------

module tb_thermal_dvfs_bisect_controller_unit;
  import tdvfs_pkg::*;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_we_i         = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i       = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i      = '0;
  logic                   s_axis_tvalid_i  = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i   = '0;
  logic                   s_axis_tuser_i   = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [2:0]             m_axis_tuser_o;

  int   fail_count;
  int   pending;
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  bit   rx_long_hold = 1'b0;
  bit   rx_hold_done = 1'b0;
  int   hold_cnt     = 0;
  cfg_t live_cfg;
  int   hot_cores [4];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  thermal_dvfs_bisect_controller_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  tb_thermal_dvfs_bisect_controller_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tuser_i    (s_axis_tuser_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: random stalls, plus one long hold-off counted here
  always @(posedge clk_i) begin
    if (rx_long_hold && !rx_hold_done) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt        <= hold_cnt + 1;
      if (hold_cnt == 59) rx_hold_done <= 1'b1;
    end else begin
      m_axis_tready_i <= (int'($urandom_range(99, 0)) >= rx_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic cfg_t make_limits(input int fmin, input int fmax, input int tlow,
                                       input int tgoal, input int thigh, input int tcrit,
                                       input int fstep, input int fine_min);
    cfg_t c;
    c.min_freq      = fmin[FREQ_W-1:0];
    c.max_freq      = fmax[FREQ_W-1:0];
    c.temp_low      = tlow[TEMP_W-1:0];
    c.temp_goal     = tgoal[TEMP_W-1:0];
    c.temp_high     = thigh[TEMP_W-1:0];
    c.temp_critical = tcrit[TEMP_W-1:0];
    c.f_step        = fstep[STEP_W-1:0];
    c.fine_floor    = fine_min[STEP_W-1:0];
    return c;
  endfunction

  // ordered band with random spacing, as a real part would be set up
  function automatic cfg_t sorted_limits();
    int fmin, tlow, tgoal, thigh, fstep;
    fmin  = int'($urandom_range(3000, 0));
    tlow  = int'($urandom_range(2500, 0)) - 2048;
    tgoal = tlow + int'($urandom_range(200, 0));
    thigh = tgoal + int'($urandom_range(200, 0));
    fstep = int'($urandom_range(400, 1));
    return make_limits(fmin, fmin + int'($urandom_range(8000, 200)), tlow, tgoal, thigh,
                       thigh + int'($urandom_range(200, 0)), fstep,
                       int'($urandom_range(60, 1)));
  endfunction

  function automatic cfg_t wild_limits();
    return make_limits(int'($urandom_range(16383, 0)), int'($urandom_range(16383, 0)),
                       int'($urandom_range(6143, 0)) - 2048,
                       int'($urandom_range(6143, 0)) - 2048,
                       int'($urandom_range(6143, 0)) - 2048,
                       int'($urandom_range(6143, 0)) - 2048,
                       int'($urandom_range(4095, 1)), int'($urandom_range(4095, 1)));
  endfunction

  // mostly around the thresholds, sometimes right on one, sometimes anywhere
  function automatic int pick_temp(input cfg_t c);
    int th [4];
    int lo_t, hi_t, sel;
    th[0] = $signed(c.temp_low);
    th[1] = $signed(c.temp_goal);
    th[2] = $signed(c.temp_high);
    th[3] = $signed(c.temp_critical);
    lo_t  = th[0];
    hi_t  = th[0];
    for (int k = 1; k < 4; k++) begin
      if (th[k] < lo_t) lo_t = th[k];
      if (th[k] > hi_t) hi_t = th[k];
    end
    sel = int'($urandom_range(99, 0));
    if (sel < 70)
      return clip(lo_t - 60 + int'($urandom_range(hi_t - lo_t + 120, 0)), -2048, 4095);
    if (sel < 85)
      return clip(th[$urandom_range(3, 0)] + int'($urandom_range(2, 0)) - 1, -2048, 4095);
    return int'($urandom_range(6143, 0)) - 2048;
  endfunction

  function automatic int pick_freq(input cfg_t c);
    int lo_f, hi_f;
    lo_f = (c.min_freq < c.max_freq) ? int'(c.min_freq) : int'(c.max_freq);
    hi_f = (c.min_freq < c.max_freq) ? int'(c.max_freq) : int'(c.min_freq);
    if ($urandom_range(99, 0) < 70)
      return clip(lo_f - 300 + int'($urandom_range(hi_f - lo_f + 600, 0)), 0, 16383);
    return int'($urandom_range(16383, 0));
  endfunction

  task automatic send_eval(input int core, input bit active, input int temp, input int freq);
    while (int'($urandom_range(99, 0)) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= active;
    s_axis_tdata_i  <= {7'b0, freq[FREQ_W-1:0], temp[TEMP_W-1:0], core[IDX_W-1:0]};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input reg_e r, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  task automatic program_limits(input cfg_t c);
    put_reg(REG_MIN_FREQ, c.min_freq);
    put_reg(REG_MAX_FREQ, c.max_freq);
    put_reg(REG_TEMP_LOW, {1'b0, c.temp_low});
    put_reg(REG_TEMP_GOAL, {1'b0, c.temp_goal});
    put_reg(REG_TEMP_HIGH, {1'b0, c.temp_high});
    put_reg(REG_TEMP_CRIT, {1'b0, c.temp_critical});
    put_reg(REG_F_STEP, {2'b0, c.f_step});
    put_reg(REG_FINE_FLOOR, {2'b0, c.fine_floor});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    live_cfg = c;
  endtask

  task automatic run_random(input int n);
    int core;
    for (int k = 0; k < 4; k++) hot_cores[k] = int'($urandom_range(63, 0));
    for (int i = 0; i < n; i++) begin
      core = ($urandom_range(99, 0) < 75) ? hot_cores[$urandom_range(3, 0)]
                                          : int'($urandom_range(63, 0));
      send_eval(core, $urandom_range(99, 0) < 90, pick_temp(live_cfg), pick_freq(live_cfg));
      if (i == n / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    cfg_t plan;
    live_cfg = make_limits(MIN_FREQ_RST, MAX_FREQ_RST, $signed(TEMP_LOW_RST),
                           $signed(TEMP_GOAL_RST), $signed(TEMP_HIGH_RST),
                           $signed(TEMP_CRIT_RST), F_STEP_RST, FINE_FLOOR_RST);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // limits straight out of reset, per-core fine step at its reset value
    send_eval(0, 1'b0, 4095, 16383);
    send_eval(63, 1'b1, 4095, 0);
    send_eval(1, 1'b1, 1441, 1100);
    send_eval(1, 1'b1, 1440, 16383);
    send_eval(2, 1'b1, -2048, 3900);
    send_eval(2, 1'b1, 959, 0);
    // bisection walk on one core: reversals halve the step down to the floor
    send_eval(3, 1'b1, 960, 2000);
    send_eval(3, 1'b1, 1280, 2200);
    send_eval(3, 1'b1, 1000, 2100);
    send_eval(3, 1'b1, 1200, 2150);
    send_eval(3, 1'b1, 1000, 2125);
    send_eval(3, 1'b1, 1120, 2150);
    send_eval(3, 1'b1, 1121, 1010);
    send_eval(4, 1'b1, 1119, 3990);
    send_eval(63, 1'b0, -1, 0);
    send_eval(5, 1'b1, -1, 8191);
    wait_drained();

    // coarse step below the fine floor: band evaluations hold once a coarse move has reset the step
    program_limits(make_limits(1000, 4000, 960, 1120, 1280, 1440, 10, 25));
    send_eval(6, 1'b1, 1500, 2000);
    send_eval(6, 1'b1, 1000, 2000);
    send_eval(3, 1'b1, 1200, 2000);
    wait_drained();

    // min above max: fine moves end at max
    program_limits(make_limits(3000, 2000, 960, 1120, 1280, 1440, 200, 1));
    send_eval(7, 1'b1, 1000, 2500);
    send_eval(7, 1'b1, 1200, 2500);
    send_eval(7, 1'b0, 1200, 2500);
    send_eval(8, 1'b1, 1500, 2500);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: plan = make_limits(MIN_FREQ_RST, MAX_FREQ_RST, $signed(TEMP_LOW_RST),
                              $signed(TEMP_GOAL_RST), $signed(TEMP_HIGH_RST),
                              $signed(TEMP_CRIT_RST), F_STEP_RST, FINE_FLOOR_RST);
        1: plan = sorted_limits();
        2: plan = make_limits(0, 16383, -2048, 1024, 4095, 4095, 4095, 1);
        3: plan = make_limits(16383, 0, -2048, -2048, -2048, -2048, 1, 4095);
        4: plan = sorted_limits();
        default: plan = wild_limits();
      endcase
      if (ph < 2) begin
        tx_idle_pct = 13;
        rx_idle_pct = 67;
      end else if (ph < 4) begin
        tx_idle_pct = 67;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      program_limits(plan);
      // result side holds off while items keep coming, so the block backs up
      if (ph == 4) rx_long_hold = 1'b1;
      run_random(230);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tdvfs_pkg.sv
hw/rtl/tdvfs_front.sv
hw/rtl/tdvfs_fifo.sv
hw/rtl/tdvfs_back.sv
hw/rtl/thermal_dvfs_bisect_controller_unit.sv
test/tb_thermal_dvfs_bisect_controller_unit_checker.sv
test/tb_thermal_dvfs_bisect_controller_unit.sv
